// ----- sv/lsr_pkg.sv -----
`timescale 1ns / 1ps

package lsr_pkg;

	localparam int unsigned DIM_MAX_DEF = 1024;

	localparam int unsigned IN_W      = 30;
	localparam int unsigned IDX_W     = 31;
	localparam int unsigned VAL_W     = 6;
	localparam int unsigned CFG_W     = 11;
	localparam int unsigned PTS_W     = 5;
	localparam int unsigned CFG_IDX_W = 2;
	localparam int unsigned NOFF      = 26;
	localparam int unsigned NFACE     = 6;
	localparam int unsigned OFF_IW    = $clog2(NOFF);

	localparam logic [CFG_IDX_W-1:0] REG_SIZE_X = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_SIZE_Y = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_SIZE_Z = 2'd2;
	localparam logic [CFG_IDX_W-1:0] REG_POINTS = 2'd3;

	localparam logic [PTS_W-1:0] POINTS_RESET = 5'd7;
	localparam logic [PTS_W-1:0] SPLIT_3D     = 5'd7;
	localparam logic [PTS_W-1:0] SPLIT_2D     = 5'd5;
	localparam logic [PTS_W-1:0] DIAG_27      = 5'd26;
	localparam logic [PTS_W-1:0] DIAG_7       = 5'd6;
	localparam logic [PTS_W-1:0] DIAG_9       = 5'd8;
	localparam logic [PTS_W-1:0] DIAG_5       = 5'd4;

	localparam logic [VAL_W-1:0] VAL_OFF_DIAG = 6'h3F;

	localparam logic [1:0] OFF_Z = 2'b00;
	localparam logic [1:0] OFF_P = 2'b01;
	localparam logic [1:0] OFF_M = 2'b11;

	// Each entry is {dx, dy, dz}; the six face neighbors come first.
	localparam logic [5:0] OFFS [NOFF] = '{
		{OFF_Z, OFF_Z, OFF_M}, {OFF_Z, OFF_Z, OFF_P}, {OFF_Z, OFF_M, OFF_Z},
		{OFF_Z, OFF_P, OFF_Z}, {OFF_M, OFF_Z, OFF_Z}, {OFF_P, OFF_Z, OFF_Z},
		{OFF_M, OFF_M, OFF_M}, {OFF_Z, OFF_M, OFF_M}, {OFF_P, OFF_M, OFF_M},
		{OFF_M, OFF_Z, OFF_M}, {OFF_P, OFF_Z, OFF_M}, {OFF_M, OFF_P, OFF_M},
		{OFF_Z, OFF_P, OFF_M}, {OFF_P, OFF_P, OFF_M},
		{OFF_M, OFF_M, OFF_Z}, {OFF_P, OFF_M, OFF_Z}, {OFF_M, OFF_P, OFF_Z},
		{OFF_P, OFF_P, OFF_Z},
		{OFF_M, OFF_M, OFF_P}, {OFF_Z, OFF_M, OFF_P}, {OFF_P, OFF_M, OFF_P},
		{OFF_M, OFF_Z, OFF_P}, {OFF_P, OFF_Z, OFF_P}, {OFF_M, OFF_P, OFF_P},
		{OFF_Z, OFF_P, OFF_P}, {OFF_P, OFF_P, OFF_P}
	};

	typedef struct packed {
		logic                bad;
		logic [IN_W-1:0]     ii;
		logic [NOFF-1:0]     mask;
		logic [PTS_W-1:0]    diag;
	} entry_t;

	typedef struct packed {
		logic full;
		logic empty;
	} q_stat_t;

endpackage

// ----- sv/lsr_front.sv -----
`timescale 1ns / 1ps

module lsr_front #(
	parameter int unsigned DIM_MAX = lsr_pkg::DIM_MAX_DEF
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             start,
	output logic                             busy,
	input  logic [lsr_pkg::IN_W-1:0]         row_index,
	input  logic [$clog2(DIM_MAX+1)-1:0]     nx,
	input  logic [$clog2(DIM_MAX+1)-1:0]     ny,
	input  logic [$clog2(DIM_MAX+1)-1:0]     nz,
	input  logic [2*$clog2(DIM_MAX+1)-1:0]   plane,
	input  logic [lsr_pkg::PTS_W-1:0]        req_points,
	input  lsr_pkg::q_stat_t                 q_stat,
	output logic                             push,
	output lsr_pkg::entry_t                  entry
);

	localparam int unsigned DW   = $clog2(DIM_MAX + 1);
	localparam int unsigned NW   = 3 * DW;
	localparam int unsigned RW   = (NW > lsr_pkg::IN_W) ? NW : lsr_pkg::IN_W;
	localparam int unsigned CNTW = $clog2(DW);

	localparam logic [2:0] F_IDLE = 3'd0;
	localparam logic [2:0] F_NMUL = 3'd1;
	localparam logic [2:0] F_CHK  = 3'd2;
	localparam logic [2:0] F_DIVZ = 3'd3;
	localparam logic [2:0] F_DIVY = 3'd4;
	localparam logic [2:0] F_PUSH = 3'd5;

	logic                        inbuf_v_q;
	logic [lsr_pkg::IN_W-1:0]    inbuf_q;
	logic [2:0]                  state_q;
	logic [lsr_pkg::IN_W-1:0]    ii_q;
	logic [NW-1:0]               n_q;
	logic [RW-1:0]               rem_q;
	logic [RW-1:0]               dv_q;
	logic [DW-1:0]               quo_q;
	logic [CNTW-1:0]             cnt_q;
	logic [DW-1:0]               iz_q;
	logic [DW-1:0]               iy_q;
	logic                        bad_q;

	logic                        accept;
	logic                        take;
	logic                        ge;
	logic [RW-1:0]               rem_nx;
	logic [DW-1:0]               quo_nx;
	logic                        x_lo, x_hi, y_lo, y_hi, z_lo, z_hi;
	logic                        wide;
	logic [lsr_pkg::PTS_W-1:0]   diag;
	logic [lsr_pkg::NOFF-1:0]    mask;
	logic [5:0]                  off;

	function automatic logic axis_ok(input logic [1:0] code, input logic lo, input logic hi);
		logic ok;
		ok = 1'b1;
		if (code == lsr_pkg::OFF_M) begin
			ok = lo;
		end else if (code == lsr_pkg::OFF_P) begin
			ok = hi;
		end
		return ok;
	endfunction

	assign accept = start && !inbuf_v_q;
	assign busy   = inbuf_v_q;
	assign take   = (state_q == F_IDLE) && inbuf_v_q;

	assign ge     = rem_q >= dv_q;
	assign rem_nx = ge ? (rem_q - dv_q) : rem_q;
	assign quo_nx = {quo_q[DW-2:0], ge};

	assign x_lo = rem_q != '0;
	assign x_hi = (rem_q + RW'(1)) < RW'(nx);
	assign y_lo = iy_q != '0;
	assign y_hi = ({1'b0, iy_q} + (DW+1)'(1)) < {1'b0, ny};
	assign z_lo = iz_q != '0;
	assign z_hi = ({1'b0, iz_q} + (DW+1)'(1)) < {1'b0, nz};

	always_comb begin
		if (nz != DW'(1)) begin
			wide = req_points > lsr_pkg::SPLIT_3D;
			diag = wide ? lsr_pkg::DIAG_27 : lsr_pkg::DIAG_7;
		end else begin
			wide = req_points > lsr_pkg::SPLIT_2D;
			diag = wide ? lsr_pkg::DIAG_9 : lsr_pkg::DIAG_5;
		end
	end

	always_comb begin
		for (int i = 0; i < lsr_pkg::NOFF; i++) begin
			off = lsr_pkg::OFFS[i];
			mask[i] = axis_ok(off[5:4], x_lo, x_hi) && axis_ok(off[3:2], y_lo, y_hi)
				&& axis_ok(off[1:0], z_lo, z_hi) && (i < lsr_pkg::NFACE || wide);
		end
	end

	assign push       = (state_q == F_PUSH) && !q_stat.full;
	assign entry.bad  = bad_q;
	assign entry.ii   = ii_q;
	assign entry.mask = bad_q ? '0 : mask;
	assign entry.diag = diag;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			inbuf_v_q <= 1'b0;
		end else if (accept) begin
			inbuf_v_q <= 1'b1;
		end else if (take) begin
			inbuf_v_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			inbuf_q <= row_index;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= F_IDLE;
		end else begin
			case (state_q)
				F_IDLE: begin
					if (take) begin
						state_q <= F_NMUL;
					end
				end
				F_NMUL: begin
					state_q <= F_CHK;
				end
				F_CHK: begin
					state_q <= (RW'(ii_q) >= RW'(n_q)) ? F_PUSH : F_DIVZ;
				end
				F_DIVZ: begin
					if (cnt_q == '0) begin
						state_q <= F_DIVY;
					end
				end
				F_DIVY: begin
					if (cnt_q == '0) begin
						state_q <= F_PUSH;
					end
				end
				F_PUSH: begin
					if (push) begin
						state_q <= F_IDLE;
					end
				end
				default: begin
					state_q <= F_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			F_IDLE: begin
				if (take) begin
					ii_q <= inbuf_q;
				end
			end
			F_NMUL: begin
				n_q <= plane * nz;
			end
			F_CHK: begin
				bad_q <= RW'(ii_q) >= RW'(n_q);
				rem_q <= RW'(ii_q);
				dv_q  <= RW'(plane) << (DW - 1);
				quo_q <= '0;
				cnt_q <= CNTW'(DW - 1);
			end
			F_DIVZ: begin
				rem_q <= rem_nx;
				if (cnt_q == '0) begin
					iz_q  <= quo_nx;
					quo_q <= '0;
					dv_q  <= RW'(nx) << (DW - 1);
					cnt_q <= CNTW'(DW - 1);
				end else begin
					quo_q <= quo_nx;
					dv_q  <= dv_q >> 1;
					cnt_q <= cnt_q - CNTW'(1);
				end
			end
			F_DIVY: begin
				rem_q <= rem_nx;
				quo_q <= quo_nx;
				dv_q  <= dv_q >> 1;
				if (cnt_q == '0) begin
					iy_q <= quo_nx;
				end else begin
					cnt_q <= cnt_q - CNTW'(1);
				end
			end
			default: begin
			end
		endcase
	end

	a_x_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == F_PUSH) && !bad_q |-> rem_q < RW'(nx))
		else $error("x coordinate out of range at push");

	a_yz_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == F_PUSH) && !bad_q |-> (iy_q < ny) && (iz_q < nz))
		else $error("y or z coordinate out of range at push");

endmodule

// ----- sv/lsr_queue.sv -----
`timescale 1ns / 1ps

module lsr_queue (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	input  lsr_pkg::entry_t   din,
	input  logic              pop,
	output lsr_pkg::entry_t   dout,
	output lsr_pkg::q_stat_t  stat
);

	lsr_pkg::entry_t mem_q [2];
	logic            wp_q;
	logic            rp_q;
	logic [1:0]      cnt_q;

	assign stat.full  = cnt_q == 2'd2;
	assign stat.empty = cnt_q == 2'd0;
	assign dout       = mem_q[rp_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wp_q] <= din;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= 1'b0;
			rp_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push) begin
				wp_q <= ~wp_q;
			end
			if (pop) begin
				rp_q <= ~rp_q;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 2'd1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 2'd1;
			end
		end
	end

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> !stat.full)
		else $error("transfer into a full queue");

	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> !stat.empty)
		else $error("transfer out of an empty queue");

endmodule

// ----- sv/lsr_back.sv -----
`timescale 1ns / 1ps

module lsr_back #(
	parameter int unsigned DIM_MAX = lsr_pkg::DIM_MAX_DEF
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  lsr_pkg::q_stat_t                     q_stat,
	input  lsr_pkg::entry_t                      head,
	output logic                                 pop,
	input  logic [$clog2(DIM_MAX+1)-1:0]         nx,
	input  logic [2*$clog2(DIM_MAX+1)-1:0]       plane,
	output logic                                 strobe,
	output logic [lsr_pkg::IDX_W-1:0]            row_out,
	output logic [lsr_pkg::IDX_W-1:0]            column_index,
	output logic signed [lsr_pkg::VAL_W-1:0]     entry_value,
	output logic                                 last_entry,
	output logic                                 bad_row
);

	localparam int unsigned DW = $clog2(DIM_MAX + 1);
	localparam int unsigned AW = 3 * DW + 1;

	logic                          act_q;
	lsr_pkg::entry_t               cur_q;
	logic [lsr_pkg::NOFF-1:0]      mask_q;
	logic                          strobe_q;
	logic [lsr_pkg::IDX_W-1:0]     row_q;
	logic [lsr_pkg::IDX_W-1:0]     col_q;
	logic [lsr_pkg::VAL_W-1:0]     val_q;
	logic                          last_q;
	logic                          bad_q;

	logic                          mask_any;
	logic                          done;
	logic                          load;
	logic [lsr_pkg::OFF_IW-1:0]    idx;
	logic [5:0]                    off;
	logic [AW-1:0]                 tx, ty, tz;
	logic [AW-1:0]                 col_nx;
	logic [lsr_pkg::IDX_W-1:0]     row_nx;

	assign mask_any = |mask_q;
	assign done     = act_q && (cur_q.bad || !mask_any);
	assign load     = (!act_q || done) && !q_stat.empty;
	assign pop      = load;

	always_comb begin
		idx = '0;
		for (int i = lsr_pkg::NOFF - 1; i >= 0; i--) begin
			if (mask_q[i]) begin
				idx = lsr_pkg::OFF_IW'(i);
			end
		end
	end

	assign off = lsr_pkg::OFFS[idx];

	always_comb begin
		case (off[5:4])
			lsr_pkg::OFF_M: tx = {AW{1'b1}};
			lsr_pkg::OFF_P: tx = AW'(1);
			default:        tx = '0;
		endcase
		case (off[3:2])
			lsr_pkg::OFF_M: ty = AW'(0) - AW'(nx);
			lsr_pkg::OFF_P: ty = AW'(nx);
			default:        ty = '0;
		endcase
		case (off[1:0])
			lsr_pkg::OFF_M: tz = AW'(0) - AW'(plane);
			lsr_pkg::OFF_P: tz = AW'(plane);
			default:        tz = '0;
		endcase
	end

	assign col_nx = AW'(cur_q.ii) + AW'(1) + tx + ty + tz;
	assign row_nx = lsr_pkg::IDX_W'(cur_q.ii) + lsr_pkg::IDX_W'(1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			act_q    <= 1'b0;
			strobe_q <= 1'b0;
		end else begin
			strobe_q <= act_q;
			if (load) begin
				act_q <= 1'b1;
			end else if (done) begin
				act_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			cur_q  <= head;
			mask_q <= head.mask;
		end else if (act_q) begin
			mask_q <= mask_q & (mask_q - lsr_pkg::NOFF'(1));
		end
		if (act_q) begin
			if (cur_q.bad) begin
				row_q  <= '0;
				col_q  <= '0;
				val_q  <= '0;
				last_q <= 1'b0;
				bad_q  <= 1'b1;
			end else if (mask_any) begin
				row_q  <= row_nx;
				col_q  <= lsr_pkg::IDX_W'(col_nx);
				val_q  <= lsr_pkg::VAL_OFF_DIAG;
				last_q <= 1'b0;
				bad_q  <= 1'b0;
			end else begin
				row_q  <= row_nx;
				col_q  <= row_nx;
				val_q  <= lsr_pkg::VAL_W'(cur_q.diag);
				last_q <= 1'b1;
				bad_q  <= 1'b0;
			end
		end
	end

	assign strobe       = strobe_q;
	assign row_out      = row_q;
	assign column_index = col_q;
	assign entry_value  = $signed(val_q);
	assign last_entry   = last_q;
	assign bad_row      = bad_q;

	a_bad_alone: assert property (@(posedge clk) disable iff (!arst_n)
		strobe_q && bad_q |-> !last_q && (row_q == '0) && (col_q == '0))
		else $error("flagged row carries entry fields");

endmodule

// ----- sv/laplacian_stencil_row_generator.sv -----
`timescale 1ns / 1ps

// Laplacian stencil row generator.
// Input: a row index is taken at a clock edge where start is high and busy
// is low. One row can wait in an input register while the previous one is
// still being decoded, so busy is only high while that register is full.
// The front decodes the index into x, y and z with a shared restoring divider
// (one quotient bit per cycle); a row outside the grid skips the division.
// Decoded rows wait in a two-entry queue for the back end, which emits one
// result per cycle on strobe while it holds a row: the in-range neighbors
// in stencil order, then the diagonal with last_entry high. A row index
// outside the grid gives one result with bad_row high. The front can decode
// the next row while the back end is still emitting results for the last.
// Results are shown for exactly one cycle; the receiver cannot stall.
// Configuration writes are always ready and must be done while idle.
// Reset returns the grid to 1x1x1 with a 7-point request and empties the block.

module laplacian_stencil_row_generator #(
	parameter int unsigned DIM_MAX = lsr_pkg::DIM_MAX_DEF
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 start,
	output logic                                 busy,
	input  logic [lsr_pkg::IN_W-1:0]             row_index,
	output logic                                 strobe,
	output logic [lsr_pkg::IDX_W-1:0]            row_out,
	output logic [lsr_pkg::IDX_W-1:0]            column_index,
	output logic signed [lsr_pkg::VAL_W-1:0]     entry_value,
	output logic                                 last_entry,
	output logic                                 bad_row,
	input  logic                                 cfg_valid,
	output logic                                 cfg_ready,
	input  logic [lsr_pkg::CFG_IDX_W-1:0]        cfg_index,
	input  logic [lsr_pkg::CFG_W-1:0]            cfg_data
);

	localparam int unsigned DW = $clog2(DIM_MAX + 1);

	logic [DW-1:0]                nx_q, ny_q, nz_q;
	logic [lsr_pkg::PTS_W-1:0]    req_q;
	logic [2*DW-1:0]              plane_q;
	logic [DW-1:0]                eff;
	logic                         cfg_wr;

	lsr_pkg::q_stat_t             q_stat;
	lsr_pkg::entry_t              push_entry;
	lsr_pkg::entry_t              head;
	logic                         push;
	logic                         pop;

	assign cfg_ready = 1'b1;
	assign cfg_wr    = cfg_valid && cfg_ready;

	always_comb begin
		if (cfg_data == '0) begin
			eff = DW'(1);
		end else if (32'(cfg_data) > 32'(DIM_MAX)) begin
			eff = DW'(DIM_MAX);
		end else begin
			eff = DW'(cfg_data);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			nx_q    <= DW'(1);
			ny_q    <= DW'(1);
			nz_q    <= DW'(1);
			req_q   <= lsr_pkg::POINTS_RESET;
			plane_q <= (2*DW)'(1);
		end else begin
			plane_q <= nx_q * ny_q;
			if (cfg_wr) begin
				case (cfg_index)
					lsr_pkg::REG_SIZE_X: nx_q  <= eff;
					lsr_pkg::REG_SIZE_Y: ny_q  <= eff;
					lsr_pkg::REG_SIZE_Z: nz_q  <= eff;
					lsr_pkg::REG_POINTS: req_q <= cfg_data[lsr_pkg::PTS_W-1:0];
					default: begin
					end
				endcase
			end
		end
	end

	lsr_front #(
		.DIM_MAX (DIM_MAX)
	) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.start      (start),
		.busy       (busy),
		.row_index  (row_index),
		.nx         (nx_q),
		.ny         (ny_q),
		.nz         (nz_q),
		.plane      (plane_q),
		.req_points (req_q),
		.q_stat     (q_stat),
		.push       (push),
		.entry      (push_entry)
	);

	lsr_queue u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.din    (push_entry),
		.pop    (pop),
		.dout   (head),
		.stat   (q_stat)
	);

	lsr_back #(
		.DIM_MAX (DIM_MAX)
	) u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.q_stat       (q_stat),
		.head         (head),
		.pop          (pop),
		.nx           (nx_q),
		.plane        (plane_q),
		.strobe       (strobe),
		.row_out      (row_out),
		.column_index (column_index),
		.entry_value  (entry_value),
		.last_entry   (last_entry),
		.bad_row      (bad_row)
	);

endmodule

// ----- bench/testbench.sv -----
`timescale 1ns / 1ps

module testbench;

	localparam int STENCIL_3D_FULL = 27;
	localparam int STENCIL_3D_FACE = 7;
	localparam int STENCIL_2D_FULL = 9;
	localparam int STENCIL_2D_FACE = 5;
	localparam longint unsigned GRID_LIMIT = 1024;
	localparam logic [lsr_pkg::IN_W-1:0] ROW_TOP = '1;
	localparam logic [lsr_pkg::CFG_W-1:0] DIM_ALL_ONES = '1;
	localparam logic [lsr_pkg::PTS_W-1:0] PTS_ALL_ONES = '1;
	localparam int CYCLE_LIMIT = 200000;
	localparam int ROWS_PER_GRID = 12;

	localparam int STEP_X [lsr_pkg::NOFF] = '{0, 0, 0, 0, -1, 1,
		-1, 0, 1, -1, 1, -1, 0, 1, -1, 1, -1, 1, -1, 0, 1, -1, 1, -1, 0, 1};
	localparam int STEP_Y [lsr_pkg::NOFF] = '{0, 0, -1, 1, 0, 0,
		-1, -1, -1, 0, 0, 1, 1, 1, -1, -1, 1, 1, -1, -1, -1, 0, 0, 1, 1, 1};
	localparam int STEP_Z [lsr_pkg::NOFF] = '{-1, 1, 0, 0, 0, 0,
		-1, -1, -1, -1, -1, -1, -1, -1, 0, 0, 0, 0, 1, 1, 1, 1, 1, 1, 1, 1};

	typedef struct packed {
		logic [lsr_pkg::IDX_W-1:0]        row;
		logic [lsr_pkg::IDX_W-1:0]        col;
		logic signed [lsr_pkg::VAL_W-1:0] val;
		logic                             last;
		logic                             bad;
	} stencil_entry_t;

	logic                                 clk;
	logic                                 arst_n;
	logic                                 start;
	logic                                 busy;
	logic [lsr_pkg::IN_W-1:0]             row_index;
	logic                                 strobe;
	logic [lsr_pkg::IDX_W-1:0]            row_out;
	logic [lsr_pkg::IDX_W-1:0]            column_index;
	logic signed [lsr_pkg::VAL_W-1:0]     entry_value;
	logic                                 last_entry;
	logic                                 bad_row;
	logic                                 cfg_valid;
	logic                                 cfg_ready;
	logic [lsr_pkg::CFG_IDX_W-1:0]        cfg_index;
	logic [lsr_pkg::CFG_W-1:0]            cfg_data;

	stencil_entry_t pending_entries [$];
	logic [lsr_pkg::CFG_W-1:0] grid_sx, grid_sy, grid_sz;
	logic [lsr_pkg::PTS_W-1:0] grid_pts;
	int fail_count;
	int cycle_count;
	int sender_idle_pct;

	laplacian_stencil_row_generator DUT (
		.clk          (clk),
		.arst_n       (arst_n),
		.start        (start),
		.busy         (busy),
		.row_index    (row_index),
		.strobe       (strobe),
		.row_out      (row_out),
		.column_index (column_index),
		.entry_value  (entry_value),
		.last_entry   (last_entry),
		.bad_row      (bad_row),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data)
	);

	initial clk = 1'b0;
	always #1 clk = ~clk;

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("Simulation FAILED");
			$finish;
		end
	end

	function automatic longint unsigned eff_dim(input logic [lsr_pkg::CFG_W-1:0] s);
		if (s == 0)
			return 1;
		if (s > GRID_LIMIT)
			return GRID_LIMIT;
		return s;
	endfunction

	function automatic void predict_row(input logic [lsr_pkg::IN_W-1:0] idx);
		longint unsigned nx, ny, nz, plane, ix, iy, iz, lin;
		longint x, y, z;
		int pts, n_off;
		stencil_entry_t e;
		nx = eff_dim(grid_sx);
		ny = eff_dim(grid_sy);
		nz = eff_dim(grid_sz);
		plane = nx * ny;
		e = '0;
		if (idx >= plane * nz) begin
			e.bad = 1'b1;
			pending_entries.push_back(e);
			return;
		end
		if (nz > 1)
			pts = (grid_pts > STENCIL_3D_FACE) ? STENCIL_3D_FULL : STENCIL_3D_FACE;
		else
			pts = (grid_pts > STENCIL_2D_FACE) ? STENCIL_2D_FULL : STENCIL_2D_FACE;
		n_off = (pts == STENCIL_3D_FULL || pts == STENCIL_2D_FULL) ?
			lsr_pkg::NOFF : lsr_pkg::NFACE;
		iz = idx / plane;
		iy = (idx - iz * plane) / nx;
		ix = idx - iz * plane - iy * nx;
		e.row = lsr_pkg::IDX_W'(idx + 1);
		e.val = lsr_pkg::VAL_W'(-1);
		for (int k = 0; k < n_off; k++) begin
			x = longint'(ix) + STEP_X[k];
			y = longint'(iy) + STEP_Y[k];
			z = longint'(iz) + STEP_Z[k];
			if (x >= 0 && x < longint'(nx) && y >= 0 && y < longint'(ny)
					&& z >= 0 && z < longint'(nz)) begin
				lin = longint'(x) + nx * longint'(y) + plane * longint'(z);
				e.col = lsr_pkg::IDX_W'(lin + 1);
				pending_entries.push_back(e);
			end
		end
		e.col = lsr_pkg::IDX_W'(idx + 1);
		e.val = lsr_pkg::VAL_W'(pts - 1);
		e.last = 1'b1;
		pending_entries.push_back(e);
	endfunction

	function automatic void compare_field(input string field, input longint want,
			input longint got);
		if (want != got) begin
			$display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
			fail_count++;
		end
	endfunction

	always @(negedge clk) begin
		stencil_entry_t want;
		if (arst_n && strobe) begin
			if (pending_entries.size() == 0) begin
				$display("%0t: unexpected result, expected none, actual row %0d col %0d bad %0d",
					$time, row_out, column_index, bad_row);
				fail_count++;
			end else begin
				want = pending_entries.pop_front();
				compare_field("row_out", want.row, row_out);
				compare_field("column_index", want.col, column_index);
				compare_field("entry_value", want.val, entry_value);
				compare_field("last_entry", want.last, last_entry);
				compare_field("bad_row", want.bad, bad_row);
			end
		end
	end

	// Leaves start high after the transfer so back-to-back rows need no gap.
	task automatic send_row(input logic [lsr_pkg::IN_W-1:0] idx);
		while ($urandom_range(99) < sender_idle_pct) begin
			start <= 1'b0;
			@(posedge clk);
		end
		start <= 1'b1;
		row_index <= idx;
		@(negedge clk);
		while (busy) begin
			@(posedge clk);
			@(negedge clk);
		end
		@(posedge clk);
		predict_row(idx);
	endtask

	task automatic write_reg(input logic [lsr_pkg::CFG_IDX_W-1:0] idx,
			input logic [lsr_pkg::CFG_W-1:0] data);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		@(negedge clk);
		while (!cfg_ready) begin
			@(posedge clk);
			@(negedge clk);
		end
		@(posedge clk);
		case (idx)
			lsr_pkg::REG_SIZE_X: grid_sx = data;
			lsr_pkg::REG_SIZE_Y: grid_sy = data;
			lsr_pkg::REG_SIZE_Z: grid_sz = data;
			lsr_pkg::REG_POINTS: grid_pts = data[lsr_pkg::PTS_W-1:0];
			default: begin
			end
		endcase
	endtask

	task automatic wait_idle();
		start <= 1'b0;
		while (pending_entries.size() != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	task automatic set_grid(input logic [lsr_pkg::CFG_W-1:0] sx,
			input logic [lsr_pkg::CFG_W-1:0] sy,
			input logic [lsr_pkg::CFG_W-1:0] sz, input logic [lsr_pkg::PTS_W-1:0] pts);
		wait_idle();
		write_reg(lsr_pkg::REG_SIZE_X, sx);
		write_reg(lsr_pkg::REG_SIZE_Y, sy);
		write_reg(lsr_pkg::REG_SIZE_Z, sz);
		write_reg(lsr_pkg::REG_POINTS, lsr_pkg::CFG_W'(pts));
		cfg_valid <= 1'b0;
	endtask

	function automatic longint unsigned pick_coord(input longint unsigned n);
		case ($urandom_range(4))
			0: return 0;
			1: return n - 1;
			2: return (n > 1) ? 1 : 0;
			3: return (n > 1) ? n - 2 : 0;
			default: return $urandom_range(n - 1);
		endcase
	endfunction

	function automatic logic [lsr_pkg::IN_W-1:0] pick_row();
		longint unsigned nx, ny, nz, v;
		int r;
		nx = eff_dim(grid_sx);
		ny = eff_dim(grid_sy);
		nz = eff_dim(grid_sz);
		r = $urandom_range(9);
		if (r == 0)
			return lsr_pkg::IN_W'($urandom);
		if (r == 1) begin
			v = nx * ny * nz + $urandom_range(2);
			return (v > ROW_TOP) ? lsr_pkg::IN_W'($urandom) : lsr_pkg::IN_W'(v);
		end
		v = pick_coord(nx) + nx * pick_coord(ny) + nx * ny * pick_coord(nz);
		return lsr_pkg::IN_W'(v);
	endfunction

	function automatic logic [lsr_pkg::CFG_W-1:0] pick_dim();
		case ($urandom_range(19))
			0: return '0;
			1: return lsr_pkg::CFG_W'($urandom_range(GRID_LIMIT + 1, DIM_ALL_ONES));
			2: return lsr_pkg::CFG_W'(GRID_LIMIT);
			3: return lsr_pkg::CFG_W'($urandom_range(1, GRID_LIMIT));
			4: return lsr_pkg::CFG_W'(1);
			default: return lsr_pkg::CFG_W'($urandom_range(2, 6));
		endcase
	endfunction

	task automatic test_reset_grid();
		send_row(0);
		send_row(1);
		send_row(ROW_TOP);
	endtask

	task automatic test_3d_stencils();
		set_grid(3, 3, 3, STENCIL_3D_FULL);
		send_row(0);
		send_row(13);
		send_row(26);
		send_row(27);
		set_grid(3, 3, 3, STENCIL_3D_FACE);
		send_row(0);
		send_row(13);
	endtask

	task automatic test_2d_stencils();
		set_grid(4, 3, 1, 0);
		send_row(0);
		send_row(5);
		set_grid(4, 3, 1, PTS_ALL_ONES);
		send_row(5);
		send_row(11);
		send_row(12);
	endtask

	task automatic test_size_clamping();
		set_grid(0, DIM_ALL_ONES, lsr_pkg::CFG_W'(GRID_LIMIT + 1), STENCIL_3D_FACE + 1);
		send_row(0);
		send_row(lsr_pkg::IN_W'((GRID_LIMIT * GRID_LIMIT) - 1));
		send_row(lsr_pkg::IN_W'(GRID_LIMIT * GRID_LIMIT));
		set_grid(DIM_ALL_ONES, DIM_ALL_ONES, DIM_ALL_ONES, STENCIL_3D_FULL);
		send_row(0);
		send_row(ROW_TOP);
		send_row(lsr_pkg::IN_W'((GRID_LIMIT * GRID_LIMIT * GRID_LIMIT) / 2 + GRID_LIMIT + 1));
	endtask

	task automatic test_random_rows(input int idle_pct);
		logic [lsr_pkg::CFG_W-1:0] sz;
		sender_idle_pct = idle_pct;
		repeat (3) begin
			sz = ($urandom_range(2) == 0) ? lsr_pkg::CFG_W'(1) : pick_dim();
			set_grid(pick_dim(), pick_dim(), sz,
				lsr_pkg::PTS_W'($urandom_range(0, PTS_ALL_ONES)));
			repeat (ROWS_PER_GRID)
				send_row(pick_row());
		end
	endtask

	initial begin
		arst_n = 1'b0;
		start = 1'b0;
		row_index = '0;
		cfg_valid = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		fail_count = 0;
		cycle_count = 0;
		sender_idle_pct = 0;
		grid_sx = 1;
		grid_sy = 1;
		grid_sz = 1;
		grid_pts = lsr_pkg::POINTS_RESET;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_reset_grid();
		test_3d_stencils();
		test_2d_stencils();
		test_size_clamping();
		test_random_rows(0);
		test_random_rows(78);
		test_random_rows(0);
		test_random_rows(29);

		wait_idle();
		repeat (60) @(posedge clk);
		if (fail_count == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

endmodule
